/* src/ils_pkg.sv */
// Shared types and constants for the indexed list store.
package ils_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int LEN_W = 7;

  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic [2:0] {
    CMD_GET      = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_INS_TAIL = 3'd2,
    CMD_INS_AT   = 3'd3,
    CMD_DEL      = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [POS_W-1:0]   position;
    logic [VAL_W-1:0]   data_in;
  } cmd_req_t;

  typedef struct packed {
    logic [VAL_W-1:0]   read_value;
    logic               hit;
    logic               applied;
    logic               full_refused;
    logic [LEN_W-1:0]   length;
  } result_t;

endpackage

/* src/ils_core.sv */
// Entry memory and shift sequencer of the indexed list store.
module ils_core #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  ils_pkg::cmd_req_t req,
  input  logic              req_valid,
  output logic              req_ready,
  output ils_pkg::result_t  res,
  output logic              res_valid,
  input  logic              res_ready
);
  import ils_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam logic [CW-1:0] CAP_VAL = CW'(CAPACITY);

  typedef enum logic [2:0] {
    IDLE,
    GET_WAIT,
    INS_RD,
    INS_WR,
    DEL_RD,
    DEL_WR,
    DONE
  } state_t;

  state_t state;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rdata;

  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    ins_pos;
  logic [VAL_W-1:0] val;

  logic [CMPW-1:0]  pos_ext;
  logic [CMPW-1:0]  count_ext;
  logic             pos_lt_count;
  logic             pos_le_count;
  logic             full;

  logic [CW-1:0]    idx_step;
  logic [CW-1:0]    count_inc;
  logic [CW-1:0]    count_dec;
  logic             ins_last;
  logic             del_last;

  logic             rd_en;
  logic [AW-1:0]    raddr;
  logic             wr_en;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;

  // Assemble one result word.
  function automatic result_t pack_result(logic [VAL_W-1:0] value, logic got_hit,
                                          logic did_apply, logic refused,
                                          logic [CW-1:0] len);
    result_t r;
    r.read_value   = value;
    r.hit          = got_hit;
    r.applied      = did_apply;
    r.full_refused = refused;
    r.length       = LEN_W'(len);
    return r;
  endfunction

  assign pos_ext      = CMPW'(req.position);
  assign count_ext    = CMPW'(count);
  assign pos_lt_count = pos_ext < count_ext;
  assign pos_le_count = pos_ext <= count_ext;
  assign full         = count >= CAP_VAL;

  // One shared stepper: walk down while opening a slot, up while closing one.
  assign idx_step  = idx + ((state == DEL_RD) ? CW'(1) : {CW{1'b1}});
  assign count_inc = count + CW'(1);
  assign count_dec = count - CW'(1);
  assign ins_last  = idx == ins_pos;
  assign del_last  = idx_step == count;

  always_comb begin
    rd_en = 1'b0;
    raddr = idx[AW-1:0];
    wr_en = 1'b0;
    waddr = idx[AW-1:0];
    wdata = rdata;
    case (state)
      IDLE: begin
        rd_en = req_valid && (req.cmd == CMD_GET) && pos_lt_count;
        raddr = AW'(req.position);
      end
      INS_RD: begin
        if (ins_last) begin
          wr_en = 1'b1;
          wdata = val;
        end else begin
          rd_en = 1'b1;
          raddr = idx_step[AW-1:0];
        end
      end
      INS_WR: wr_en = 1'b1;
      DEL_RD: begin
        rd_en = !del_last;
        raddr = idx_step[AW-1:0];
      end
      DEL_WR: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      count <= '0;
    end else begin
      case (state)
        IDLE: begin
          if (req_valid) begin
            val <= req.data_in;
            case (req.cmd)
              CMD_GET: begin
                if (pos_lt_count) begin
                  state <= GET_WAIT;
                end else begin
                  res   <= pack_result(MISS_VALUE, 1'b0, 1'b0, 1'b0, count);
                  state <= DONE;
                end
              end
              CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
                if (req.cmd == CMD_INS_AT && !pos_le_count) begin
                  res   <= pack_result('0, 1'b0, 1'b0, 1'b0, count);
                  state <= DONE;
                end else if (full) begin
                  res   <= pack_result('0, 1'b0, 1'b0, 1'b1, count);
                  state <= DONE;
                end else begin
                  idx   <= count;
                  state <= INS_RD;
                  case (req.cmd)
                    CMD_INS_HEAD: ins_pos <= '0;
                    CMD_INS_TAIL: ins_pos <= count;
                    default:      ins_pos <= CW'(req.position);
                  endcase
                end
              end
              CMD_DEL: begin
                if (pos_lt_count) begin
                  idx   <= CW'(req.position);
                  state <= DEL_RD;
                end else begin
                  res   <= pack_result('0, 1'b0, 1'b0, 1'b0, count);
                  state <= DONE;
                end
              end
              default: begin
                res   <= pack_result('0, 1'b0, 1'b0, 1'b0, count);
                state <= DONE;
              end
            endcase
          end
        end
        GET_WAIT: begin
          res   <= pack_result(rdata, 1'b1, 1'b0, 1'b0, count);
          state <= DONE;
        end
        INS_RD: begin
          if (ins_last) begin
            count <= count_inc;
            res   <= pack_result('0, 1'b0, 1'b1, 1'b0, count_inc);
            state <= DONE;
          end else begin
            state <= INS_WR;
          end
        end
        INS_WR: begin
          idx   <= idx_step;
          state <= INS_RD;
        end
        DEL_RD: begin
          if (del_last) begin
            count <= count_dec;
            res   <= pack_result('0, 1'b0, 1'b1, 1'b0, count_dec);
            state <= DONE;
          end else begin
            state <= DEL_WR;
          end
        end
        DEL_WR: begin
          idx   <= idx + CW'(1);
          state <= DEL_RD;
        end
        DONE: begin
          if (res_ready) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign req_ready = state == IDLE;
  assign res_valid = state == DONE;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CAP_VAL)
    else $error("entry count above capacity");

  a_count_moves_at_end: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> state == DONE)
    else $error("entry count changed outside command completion");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $countones({res.hit, res.applied, res.full_refused}) <= 1)
    else $error("more than one result flag set");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == INS_RD || state == INS_WR) |-> idx < CAP_VAL && idx >= ins_pos)
    else $error("insert shift index out of range");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result changed before it was taken");

endmodule

/* src/indexed_list_store.sv */
// Top level of the indexed list store: stream ports and result register.
//
//  port group | direction | tdata (low bit up)                 | tuser (low bit up)
//  s_*        | in        | position[6:0], data_in[38:7], pad  | cmd[2:0]
//  m_*        | out       | read_value[31:0], length[38:32], pad | hit, applied, full_refused
//
// A get hit reads the entry memory before its result is ready; a miss, a refused,
// ignored or unknown command returns its result with no memory access. An insert or
// delete that applies does one memory read and one write per moved entry.
// Reset clears the entry count and returns the store to idle; entry contents stay as they are.
// One command is in flight at a time; s_tready drops from accept until the
// result has moved into the output register, which a stalled m_tready holds.
module indexed_list_store #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // position[6:0], data_in[38:7], zero pad
  input  logic [2:0]  s_tuser,   // cmd[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // read_value[31:0], length[38:32], zero pad
  output logic [2:0]  m_tuser    // hit, applied, full_refused
);
  import ils_pkg::*;

  cmd_req_t req;
  result_t  res;
  logic     res_valid;
  logic     res_ready;

  assign req.cmd      = cmd_t'(s_tuser);
  assign req.position = s_tdata[POS_W-1:0];
  assign req.data_in  = s_tdata[POS_W +: VAL_W];

  ils_core #(
    .CAPACITY (CAPACITY)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .req_valid (s_tvalid),
    .req_ready (s_tready),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready)
  );

  assign res_ready = !m_tvalid || m_tready;

  // Load the output word when the register is empty or draining.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {1'b0, res.length, res.read_value};
      m_tuser <= {res.full_refused, res.applied, res.hit};
    end
  end

endmodule
